FILE: rtl/linear_angle_sine_arm_converter_top_assert.svh
// Assertion macros for the sine-arm converter checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef LINEAR_ANGLE_SINE_ARM_CONVERTER_TOP_ASSERT_SVH
`define LINEAR_ANGLE_SINE_ARM_CONVERTER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define LASAC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lasac assertion failed");

// next-cycle implication, off during reset
`define LASAC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lasac assertion failed");

// holds at every edge while reset is asserted
`define LASAC_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |-> (cons)) \
        else $error("lasac reset assertion failed");

`endif

FILE: rtl/lasac_pkg.sv
// Shared types, constants and the arctangent table for the sine-arm converter.
// No dependencies.
`timescale 1ns / 1ps
package lasac_pkg;

    localparam int ARM_W     = 17;
    localparam int VAL_W     = 24;
    localparam int DIV_W     = 50;   // divider numerator / quotient width
    localparam int DREM_W    = 17;   // divider remainder width
    localparam int ISQ_IN_W  = 62;
    localparam int ISQ_STEPS = 31;
    localparam int ROOT_W    = 31;
    localparam int ISQ_REM_W = 35;
    localparam int CW        = 34;   // CORDIC datapath width

    localparam logic REQ_STEPS_TO_MDEG = 1'b0;
    localparam logic REQ_MDEG_TO_STEPS = 1'b1;

    localparam logic [ARM_W-1:0]     ARM_RESET  = 17'd12000;
    localparam logic [ARM_W-1:0]     DEG_DIV    = 17'd5625;     // 360000 / 64
    localparam logic [DIV_W-1:0]     DEG_BIAS   = 50'd2812;     // 180000 / 64, floored
    localparam logic [DIV_W-1:0]     Q_ONE      = 50'd1073741824;
    localparam logic signed [CW-1:0] GAIN_INV   = 34'sd652032874;
    localparam logic [18:0]          MDEG_SCALE = 19'd360000;
    localparam logic [50:0]          ROUND_Q    = 51'd41943040; // 5 * 2^23
    localparam logic [27:0]          RECIP5     = 28'd214748365; // ceil(2^30 / 5)
    localparam logic [VAL_W-1:0]     MDEG_90    = 24'd90000;

    typedef struct packed {
        logic                    req_type;
        logic signed [VAL_W-1:0] in_value;
    } lasac_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_value;
        logic                    out_of_range;
    } lasac_out_t;

    // per-item control that rides along the pipeline
    typedef struct packed {
        logic mode;   // request type
        logic neg;    // input sign, used for saturation
        logic sat;    // force +-90 degrees
        logic flag;   // out-of-range flag
        logic zero;   // zero input (force zero result after the divider)
    } lasac_ctl_t;

    // binary angle atan(2^-i), 2^32 per turn
    function automatic logic signed [CW-1:0] atan_angle(input int idx);
        logic signed [CW-1:0] a;
        case (idx)
            0:       a = 34'sd536870912;
            1:       a = 34'sd316933406;
            2:       a = 34'sd167458907;
            3:       a = 34'sd85004756;
            4:       a = 34'sd42667331;
            5:       a = 34'sd21354465;
            6:       a = 34'sd10679838;
            7:       a = 34'sd5340245;
            8:       a = 34'sd2670163;
            9:       a = 34'sd1335087;
            10:      a = 34'sd667544;
            11:      a = 34'sd333772;
            12:      a = 34'sd166886;
            13:      a = 34'sd83443;
            14:      a = 34'sd41722;
            15:      a = 34'sd20861;
            16:      a = 34'sd10430;
            17:      a = 34'sd5215;
            18:      a = 34'sd2608;
            19:      a = 34'sd1304;
            20:      a = 34'sd652;
            21:      a = 34'sd326;
            22:      a = 34'sd163;
            23:      a = 34'sd81;
            24:      a = 34'sd41;
            25:      a = 34'sd20;
            26:      a = 34'sd10;
            27:      a = 34'sd5;
            28:      a = 34'sd3;
            29:      a = 34'sd1;
            30:      a = 34'sd1;
            default: a = 34'sd0;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/lasac_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on lasac_pkg.
`timescale 1ns / 1ps
module lasac_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [lasac_pkg::DIV_W-1:0]     in_num,
    input  logic [lasac_pkg::ARM_W-1:0]     in_den,
    input  lasac_pkg::lasac_ctl_t           in_ctl,
    output logic                            out_valid,
    output logic [lasac_pkg::DIV_W-1:0]     out_quo,
    output lasac_pkg::lasac_ctl_t           out_ctl
);
    localparam int N  = lasac_pkg::DIV_W;
    localparam int RW = lasac_pkg::DREM_W;

    logic                          valid_reg [N];
    logic [N-1:0]                  w_reg     [N];   // numerator shifts out, quotient in
    logic [RW-1:0]                 rem_reg   [N];
    logic [lasac_pkg::ARM_W-1:0]   den_reg   [N];
    lasac_pkg::lasac_ctl_t         ctl_reg   [N];

    logic                          valid_src [N];
    logic [N-1:0]                  w_src     [N];
    logic [RW-1:0]                 rem_src   [N];
    logic [lasac_pkg::ARM_W-1:0]   den_src   [N];
    lasac_pkg::lasac_ctl_t         ctl_src   [N];

    logic [N-1:0]                  w_next    [N];
    logic [RW-1:0]                 rem_next  [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [RW:0] trial;
        logic        ge;
        if (k == 0) begin : g_first
            assign valid_src[k] = in_valid;
            assign w_src[k]     = in_num;
            assign rem_src[k]   = '0;
            assign den_src[k]   = in_den;
            assign ctl_src[k]   = in_ctl;
        end else begin : g_rest
            assign valid_src[k] = valid_reg[k-1];
            assign w_src[k]     = w_reg[k-1];
            assign rem_src[k]   = rem_reg[k-1];
            assign den_src[k]   = den_reg[k-1];
            assign ctl_src[k]   = ctl_reg[k-1];
        end
        assign trial       = {rem_src[k], w_src[k][N-1]};
        assign ge          = trial >= {1'b0, den_src[k]};
        assign rem_next[k] = ge ? RW'(trial - {1'b0, den_src[k]}) : trial[RW-1:0];
        assign w_next[k]   = {w_src[k][N-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int k = 0; k < N; k++) valid_reg[k] <= 1'b0;
        end else if (en) begin
            for (int k = 0; k < N; k++) valid_reg[k] <= valid_src[k];
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                w_reg[k]   <= w_next[k];
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_src[k];
                ctl_reg[k] <= ctl_src[k];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_quo   = w_reg[N-1];
    assign out_ctl   = ctl_reg[N-1];
endmodule

FILE: rtl/lasac_isqrt.sv
// Pipelined integer square root, one root bit per stage (floor result).
// Depends on lasac_pkg.
`timescale 1ns / 1ps
module lasac_isqrt (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [lasac_pkg::ISQ_IN_W-1:0]     in_v,
    input  logic signed [lasac_pkg::CW-1:0]    in_aux,
    input  lasac_pkg::lasac_ctl_t              in_ctl,
    output logic                               out_valid,
    output logic [lasac_pkg::ROOT_W-1:0]       out_root,
    output logic signed [lasac_pkg::CW-1:0]    out_aux,
    output lasac_pkg::lasac_ctl_t              out_ctl
);
    localparam int N  = lasac_pkg::ISQ_STEPS;
    localparam int VW = lasac_pkg::ISQ_IN_W;
    localparam int RW = lasac_pkg::ISQ_REM_W;
    localparam int QW = lasac_pkg::ROOT_W;

    logic                           valid_reg [N];
    logic [VW-1:0]                  v_reg     [N];
    logic [RW-1:0]                  rem_reg   [N];
    logic [QW-1:0]                  root_reg  [N];
    logic signed [lasac_pkg::CW-1:0] aux_reg  [N];
    lasac_pkg::lasac_ctl_t          ctl_reg   [N];

    logic                           valid_src [N];
    logic [VW-1:0]                  v_src     [N];
    logic [RW-1:0]                  rem_src   [N];
    logic [QW-1:0]                  root_src  [N];
    logic signed [lasac_pkg::CW-1:0] aux_src  [N];
    lasac_pkg::lasac_ctl_t          ctl_src   [N];

    logic [VW-1:0]                  v_next    [N];
    logic [RW-1:0]                  rem_next  [N];
    logic [QW-1:0]                  root_next [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [RW-1:0] cur;
        logic [RW-1:0] trial;
        logic          ge;
        if (k == 0) begin : g_first
            assign valid_src[k] = in_valid;
            assign v_src[k]     = in_v;
            assign rem_src[k]   = '0;
            assign root_src[k]  = '0;
            assign aux_src[k]   = in_aux;
            assign ctl_src[k]   = in_ctl;
        end else begin : g_rest
            assign valid_src[k] = valid_reg[k-1];
            assign v_src[k]     = v_reg[k-1];
            assign rem_src[k]   = rem_reg[k-1];
            assign root_src[k]  = root_reg[k-1];
            assign aux_src[k]   = aux_reg[k-1];
            assign ctl_src[k]   = ctl_reg[k-1];
        end
        // bring down the next two bits, try root*4+1
        assign cur          = {rem_src[k][RW-3:0], v_src[k][VW-1 -: 2]};
        assign trial        = {{(RW-QW-2){1'b0}}, root_src[k], 2'b01};
        assign ge           = cur >= trial;
        assign rem_next[k]  = ge ? cur - trial : cur;
        assign root_next[k] = {root_src[k][QW-2:0], ge};
        assign v_next[k]    = {v_src[k][VW-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int k = 0; k < N; k++) valid_reg[k] <= 1'b0;
        end else if (en) begin
            for (int k = 0; k < N; k++) valid_reg[k] <= valid_src[k];
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                v_reg[k]    <= v_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                aux_reg[k]  <= aux_src[k];
                ctl_reg[k]  <= ctl_src[k];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_aux   = aux_reg[N-1];
    assign out_ctl   = ctl_reg[N-1];
endmodule

FILE: rtl/lasac_cordic.sv
// Unrolled CORDIC, one micro-rotation per stage; vectoring or rotation per word.
// Depends on lasac_pkg (atan table, control struct).
`timescale 1ns / 1ps
module lasac_cordic #(
    parameter int STAGES = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [lasac_pkg::CW-1:0]    in_x,
    input  logic signed [lasac_pkg::CW-1:0]    in_y,
    input  logic signed [lasac_pkg::CW-1:0]    in_z,
    input  lasac_pkg::lasac_ctl_t              in_ctl,
    output logic                               out_valid,
    output logic signed [lasac_pkg::CW-1:0]    out_y,
    output logic signed [lasac_pkg::CW-1:0]    out_z,
    output lasac_pkg::lasac_ctl_t              out_ctl
);
    localparam int N = STAGES;
    localparam int W = lasac_pkg::CW;

    logic                  valid_reg [N];
    logic signed [W-1:0]   x_reg     [N];
    logic signed [W-1:0]   y_reg     [N];
    logic signed [W-1:0]   z_reg     [N];
    lasac_pkg::lasac_ctl_t ctl_reg   [N];

    logic                  valid_src [N];
    logic signed [W-1:0]   x_src     [N];
    logic signed [W-1:0]   y_src     [N];
    logic signed [W-1:0]   z_src     [N];
    lasac_pkg::lasac_ctl_t ctl_src   [N];

    logic signed [W-1:0]   x_next    [N];
    logic signed [W-1:0]   y_next    [N];
    logic signed [W-1:0]   z_next    [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;
        logic signed [W-1:0] ang;
        logic                up;
        if (k == 0) begin : g_first
            assign valid_src[k] = in_valid;
            assign x_src[k]     = in_x;
            assign y_src[k]     = in_y;
            assign z_src[k]     = in_z;
            assign ctl_src[k]   = in_ctl;
        end else begin : g_rest
            assign valid_src[k] = valid_reg[k-1];
            assign x_src[k]     = x_reg[k-1];
            assign y_src[k]     = y_reg[k-1];
            assign z_src[k]     = z_reg[k-1];
            assign ctl_src[k]   = ctl_reg[k-1];
        end
        assign dx  = y_src[k] >>> k;
        assign dy  = x_src[k] >>> k;
        assign ang = lasac_pkg::atan_angle(k);
        // vectoring drives y to zero, rotation drives z to zero
        assign up  = (ctl_src[k].mode == lasac_pkg::REQ_STEPS_TO_MDEG) ?
                     !y_src[k][W-1] : !z_src[k][W-1];
        always_comb begin
            if (ctl_src[k].mode == lasac_pkg::REQ_STEPS_TO_MDEG) begin
                x_next[k] = up ? x_src[k] + dx : x_src[k] - dx;
                y_next[k] = up ? y_src[k] - dy : y_src[k] + dy;
                z_next[k] = up ? z_src[k] + ang : z_src[k] - ang;
            end else begin
                x_next[k] = up ? x_src[k] - dx : x_src[k] + dx;
                y_next[k] = up ? y_src[k] + dy : y_src[k] - dy;
                z_next[k] = up ? z_src[k] - ang : z_src[k] + ang;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int k = 0; k < N; k++) valid_reg[k] <= 1'b0;
        end else if (en) begin
            for (int k = 0; k < N; k++) valid_reg[k] <= valid_src[k];
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                x_reg[k]   <= x_next[k];
                y_reg[k]   <= y_next[k];
                z_reg[k]   <= z_next[k];
                ctl_reg[k] <= ctl_src[k];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_y     = y_reg[N-1];
    assign out_z     = z_reg[N-1];
    assign out_ctl   = ctl_reg[N-1];
endmodule

FILE: rtl/lasac_final.sv
// Output scaling: angle to millidegrees or sine to microsteps, rounding,
// saturation and the output register. Depends on lasac_pkg.
`timescale 1ns / 1ps
module lasac_final (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic [lasac_pkg::ARM_W-1:0]        arm,
    input  logic                               in_valid,
    input  logic signed [lasac_pkg::CW-1:0]    in_y,
    input  logic signed [lasac_pkg::CW-1:0]    in_z,
    input  lasac_pkg::lasac_ctl_t              in_ctl,
    output logic                               out_valid,
    output lasac_pkg::lasac_out_t              out_word
);
    localparam int W = lasac_pkg::CW;

    logic                  f1_valid_reg, f2_valid_reg, f3_valid_reg, f4_valid_reg, f5_valid_reg;
    lasac_pkg::lasac_ctl_t f1_ctl_reg, f2_ctl_reg, f3_ctl_reg, f4_ctl_reg;
    logic                  f1_neg_reg, f2_neg_reg, f3_neg_reg, f4_neg_reg;
    logic [31:0]           f1_mag_reg;
    logic [18:0]           f1_coef_reg;
    logic [50:0]           f2_prod_reg;
    logic [26:0]           f3_val_reg;
    logic [24:0]           f4_mag_reg;
    lasac_pkg::lasac_out_t f5_word_reg;

    logic [W-1:0]          y_abs, z_abs;
    logic [31:0]           f1_mag_next;
    logic [18:0]           f1_coef_next;
    logic                  f1_neg_next;
    logic [50:0]           f2_prod_next;
    logic [26:0]           f3_val_next;
    logic [54:0]           recip_prod;
    logic [24:0]           f4_mag_next;
    logic [24:0]           signed_mag;
    lasac_pkg::lasac_out_t f5_word_next;
    logic                  is_sine;

    assign is_sine = (in_ctl.mode == lasac_pkg::REQ_MDEG_TO_STEPS);
    assign y_abs   = in_y[W-1] ? unsigned'(-in_y) : unsigned'(in_y);
    assign z_abs   = in_z[W-1] ? unsigned'(-in_z) : unsigned'(in_z);

    assign f1_mag_next  = is_sine ? y_abs[31:0] : z_abs[31:0];
    assign f1_coef_next = is_sine ? {2'b00, arm} : lasac_pkg::MDEG_SCALE;
    assign f1_neg_next  = in_ctl.sat ? in_ctl.neg : (is_sine ? in_y[W-1] : in_z[W-1]);

    assign f2_prod_next = {19'd0, f1_mag_reg} * {32'd0, f1_coef_reg};

    // sine: (|y|*arm + 5*2^23) >> 24, then /5 next stage; angle: top bits
    assign f3_val_next = (f2_ctl_reg.mode == lasac_pkg::REQ_MDEG_TO_STEPS) ?
                         27'((f2_prod_reg + lasac_pkg::ROUND_Q) >> 24) :
                         {8'd0, f2_prod_reg[50:32]};

    assign recip_prod  = {28'd0, f3_val_reg} * {27'd0, lasac_pkg::RECIP5};
    assign f4_mag_next = (f3_ctl_reg.mode == lasac_pkg::REQ_MDEG_TO_STEPS) ?
                         recip_prod[54:30] : f3_val_reg[24:0];

    assign signed_mag = f4_neg_reg ? (~f4_mag_reg + 25'd1) : f4_mag_reg;

    always_comb begin
        f5_word_next.out_of_range = f4_ctl_reg.flag;
        if (f4_ctl_reg.sat) begin
            f5_word_next.out_value = f4_neg_reg ? -signed'(lasac_pkg::MDEG_90)
                                                : signed'(lasac_pkg::MDEG_90);
        end else if (f4_ctl_reg.zero) begin
            f5_word_next.out_value = '0;
        end else begin
            f5_word_next.out_value = signed'(signed_mag[23:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            f4_valid_reg <= 1'b0;
            f5_valid_reg <= 1'b0;
        end else if (en) begin
            f1_valid_reg <= in_valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            f4_valid_reg <= f3_valid_reg;
            f5_valid_reg <= f4_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            f1_ctl_reg  <= in_ctl;
            f1_neg_reg  <= f1_neg_next;
            f1_mag_reg  <= f1_mag_next;
            f1_coef_reg <= f1_coef_next;
            f2_ctl_reg  <= f1_ctl_reg;
            f2_neg_reg  <= f1_neg_reg;
            f2_prod_reg <= f2_prod_next;
            f3_ctl_reg  <= f2_ctl_reg;
            f3_neg_reg  <= f2_neg_reg;
            f3_val_reg  <= f3_val_next;
            f4_ctl_reg  <= f3_ctl_reg;
            f4_neg_reg  <= f3_neg_reg;
            f4_mag_reg  <= f4_mag_next;
            f5_word_reg <= f5_word_next;
        end
    end

    assign out_valid = f5_valid_reg;
    assign out_word  = f5_word_reg;
endmodule

FILE: rtl/linear_angle_sine_arm_converter_top.sv
// Top level of the sine-arm converter: config register, front end, glue stages.
// Depends on lasac_pkg, lasac_div, lasac_isqrt, lasac_cordic, lasac_final.
`timescale 1ns / 1ps
// Sine-arm converter, microsteps <-> millidegrees.
//
// Channels: input words (req_type, in_value) on in_valid/in_stall, result
// words (out_value, out_of_range) on out_valid/out_stall. A word moves on a
// rising edge with valid high and stall low. The arm length (um) is written
// through cfg_valid/cfg_data; cfg_ready is always high. Write it only while
// no word is in flight.
//
// Throughput: one word per cycle unless a held result stalls the pipeline.
// Pipeline chain: 1 front-end stage, 50 divider stages (one quotient bit
// each), 2 glue stages, 31 square-root stages, one CORDIC stage per
// micro-rotation, and 5 output stages with the output register last.
//
// Stall: the whole pipeline holds while a result waits under out_stall;
// in_stall is raised only then. Nothing is lost or repeated.
// Reset: all valid bits clear, arm length returns to 12000 um.
module linear_angle_sine_arm_converter_top #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lasac_pkg::ARM_W-1:0]  cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  lasac_pkg::lasac_in_t         in_word,
    output logic                         out_valid,
    input  logic                         out_stall,
    output lasac_pkg::lasac_out_t        out_word
);
    localparam int W = lasac_pkg::CW;

    logic                        en;
    logic [lasac_pkg::ARM_W-1:0] arm_reg;

    // global advance: everything moves unless a held result blocks the end
    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            arm_reg <= lasac_pkg::ARM_RESET;
        else if (cfg_valid)
            arm_reg <= cfg_data;
    end

    // ---- front end: numerator and divisor for the shared divider ----
    // steps:  |s| * 5 * 2^24 / arm       (Q2.30 arcsine argument)
    // angle:  (|a| * 2^26 + 2812) / 5625 (= round(|a| * 2^32 / 360000))
    logic [23:0]                 in_mag;
    logic [25:0]                 mag5;
    logic [lasac_pkg::DIV_W-1:0] s0_num_next;
    logic [lasac_pkg::ARM_W-1:0] s0_den_next;
    lasac_pkg::lasac_ctl_t       s0_ctl_next;

    logic                        s0_valid_reg;
    logic [lasac_pkg::DIV_W-1:0] s0_num_reg;
    logic [lasac_pkg::ARM_W-1:0] s0_den_reg;
    lasac_pkg::lasac_ctl_t       s0_ctl_reg;

    assign in_mag = in_word.in_value[23] ? unsigned'(~in_word.in_value + 24'sd1)
                                         : unsigned'(in_word.in_value);
    assign mag5   = {in_mag, 2'b00} + {2'b00, in_mag};

    always_comb begin
        s0_ctl_next.mode = in_word.req_type;
        s0_ctl_next.neg  = in_word.in_value[23];
        s0_ctl_next.sat  = 1'b0;
        s0_ctl_next.flag = 1'b0;
        s0_ctl_next.zero = (in_word.in_value == '0);
        if (in_word.req_type == lasac_pkg::REQ_MDEG_TO_STEPS) begin
            s0_num_next = {in_mag, 26'd0} + lasac_pkg::DEG_BIAS;
            s0_den_next = lasac_pkg::DEG_DIV;
        end else begin
            s0_num_next = {mag5, 24'd0};
            s0_den_next = arm_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s0_num_reg <= s0_num_next;
            s0_den_reg <= s0_den_next;
            s0_ctl_reg <= s0_ctl_next;
        end
    end

    logic                        dv_valid;
    logic [lasac_pkg::DIV_W-1:0] dv_quo;
    lasac_pkg::lasac_ctl_t       dv_ctl;

    lasac_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_valid_reg),
        .in_num    (s0_num_reg),
        .in_den    (s0_den_reg),
        .in_ctl    (s0_ctl_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_ctl   (dv_ctl)
    );

    // ---- glue 1: signed quotient, r^2, saturation decision ----
    logic [31:0]           qsel;
    logic [31:0]           p1_aux_next;
    logic [59:0]           p1_sq_next;
    lasac_pkg::lasac_ctl_t p1_ctl_next;
    logic                  q_ge_one;
    logic                  q_eq_one;

    logic                  p1_valid_reg;
    logic [31:0]           p1_aux_reg;
    logic [59:0]           p1_sq_reg;
    lasac_pkg::lasac_ctl_t p1_ctl_reg;

    assign qsel        = (dv_ctl.mode == lasac_pkg::REQ_MDEG_TO_STEPS) ? dv_quo[31:0]
                                                                      : {2'b00, dv_quo[29:0]};
    assign p1_aux_next = dv_ctl.neg ? (~qsel + 32'd1) : qsel;
    assign p1_sq_next  = {30'd0, dv_quo[29:0]} * {30'd0, dv_quo[29:0]};
    assign q_ge_one    = |dv_quo[lasac_pkg::DIV_W-1:30];
    assign q_eq_one    = (dv_quo == lasac_pkg::Q_ONE);

    always_comb begin
        p1_ctl_next      = dv_ctl;
        p1_ctl_next.sat  = 1'b0;
        p1_ctl_next.flag = 1'b0;
        p1_ctl_next.zero = 1'b0;
        if (dv_ctl.mode == lasac_pkg::REQ_STEPS_TO_MDEG) begin
            if (arm_reg == '0) begin
                // zero arm: zero steps give zero, anything else saturates
                p1_ctl_next.zero = dv_ctl.zero;
                p1_ctl_next.sat  = !dv_ctl.zero;
                p1_ctl_next.flag = !dv_ctl.zero;
            end else begin
                p1_ctl_next.sat  = q_ge_one;
                p1_ctl_next.flag = q_ge_one && !q_eq_one;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (en)
            p1_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk) begin
        if (en) begin
            p1_aux_reg <= p1_aux_next;
            p1_sq_reg  <= p1_sq_next;
            p1_ctl_reg <= p1_ctl_next;
        end
    end

    // ---- glue 2: 2^60 - r^2 for the root; fold angle into [-90, 90] ----
    logic [lasac_pkg::ISQ_IN_W-1:0] p2_v_next;
    logic [31:0]                    folded;
    logic [31:0]                    aux_sel;
    logic signed [W-1:0]            p2_aux_next;

    logic                           p2_valid_reg;
    logic [lasac_pkg::ISQ_IN_W-1:0] p2_v_reg;
    logic signed [W-1:0]            p2_aux_reg;
    lasac_pkg::lasac_ctl_t          p2_ctl_reg;

    assign p2_v_next   = (lasac_pkg::ISQ_IN_W'(1) << 60) - {2'b00, p1_sq_reg};
    // second and third quadrant reflect about 90 degrees (a becomes 180 - a)
    assign folded      = (p1_aux_reg > 32'h4000_0000 && p1_aux_reg < 32'hC000_0000) ?
                         (32'h8000_0000 - p1_aux_reg) : p1_aux_reg;
    assign aux_sel     = (p1_ctl_reg.mode == lasac_pkg::REQ_MDEG_TO_STEPS) ? folded
                                                                          : p1_aux_reg;
    assign p2_aux_next = signed'({{(W-32){aux_sel[31]}}, aux_sel});

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (en)
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk) begin
        if (en) begin
            p2_v_reg   <= p2_v_next;
            p2_aux_reg <= p2_aux_next;
            p2_ctl_reg <= p1_ctl_reg;
        end
    end

    // ---- square root (angle words pass through untouched) ----
    logic                         sq_valid;
    logic [lasac_pkg::ROOT_W-1:0] sq_root;
    logic signed [W-1:0]          sq_aux;
    lasac_pkg::lasac_ctl_t        sq_ctl;

    lasac_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p2_valid_reg),
        .in_v      (p2_v_reg),
        .in_aux    (p2_aux_reg),
        .in_ctl    (p2_ctl_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_aux   (sq_aux),
        .out_ctl   (sq_ctl)
    );

    // ---- CORDIC: vectoring (x=root, y=r) or rotation (x=1/K, z=angle) ----
    logic                sine_req;
    logic signed [W-1:0] cx, cy, cz;

    assign sine_req = (sq_ctl.mode == lasac_pkg::REQ_MDEG_TO_STEPS);
    assign cx = sine_req ? lasac_pkg::GAIN_INV : signed'({{(W-lasac_pkg::ROOT_W){1'b0}}, sq_root});
    assign cy = sine_req ? '0 : sq_aux;
    assign cz = sine_req ? sq_aux : '0;

    logic                  cd_valid;
    logic signed [W-1:0]   cd_y, cd_z;
    lasac_pkg::lasac_ctl_t cd_ctl;

    lasac_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_x      (cx),
        .in_y      (cy),
        .in_z      (cz),
        .in_ctl    (sq_ctl),
        .out_valid (cd_valid),
        .out_y     (cd_y),
        .out_z     (cd_z),
        .out_ctl   (cd_ctl)
    );

    lasac_final u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .arm       (arm_reg),
        .in_valid  (cd_valid),
        .in_y      (cd_y),
        .in_z      (cd_z),
        .in_ctl    (cd_ctl),
        .out_valid (out_valid),
        .out_word  (out_word)
    );
endmodule

FILE: rtl/lasac_checker.sv
// Port-level checker for the sine-arm converter, bound to the top level.
// Depends on lasac_pkg and linear_angle_sine_arm_converter_top_assert.svh.
`timescale 1ns / 1ps
`include "linear_angle_sine_arm_converter_top_assert.svh"
module lasac_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input lasac_pkg::lasac_out_t out_word
);
    // a held result stays put
    `LASAC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
    // input is only held back by a blocked result
    `LASAC_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall)
    // the flag only comes with a saturated angle
    `LASAC_ASSERT_IMPL(a_sat_value, out_valid && out_word.out_of_range, out_word.out_value == 24'sd90000 || out_word.out_value == -24'sd90000)
    // nothing is presented during reset
    `LASAC_ASSERT_RST(a_rst_idle, !out_valid)
endmodule

bind linear_angle_sine_arm_converter_top lasac_checker u_lasac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
